>>> design/burst_locked_write_request_merger_core_macros.svh
// Assertion macros for the burst-locked write request merger.
// Used by the top level; relies on signals clk and rst in the including scope.
`ifndef BURST_LOCKED_WRITE_REQUEST_MERGER_CORE_MACROS_SVH
`define BURST_LOCKED_WRITE_REQUEST_MERGER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define BWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/bwm_pkg.sv
// Shared types and constants for the burst-locked write request merger.
// No dependencies; imported by every module of the block.
package bwm_pkg;

  localparam int SIZE_W       = 16;
  localparam int PAYLOAD_W    = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int BEAT_BYTES   = 32;

  localparam logic [SIZE_W-1:0]    BEAT_SIZE    = SIZE_W'(BEAT_BYTES);
  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK = {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - PAYLOAD_BITS);

  localparam logic SRC_PAIR   = 1'b0;
  localparam logic SRC_SINGLE = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0]    size;
    logic [PAYLOAD_W-1:0] payload;
  } part_t;

  typedef struct packed {
    logic  pair_offer;
    part_t pair_first;
    part_t pair_second;
    logic  pair_has_second;
    logic  single_offer;
    part_t single;
  } item_t;

  typedef struct packed {
    logic  out_valid;
    part_t sent;
    logic  out_source;
    logic  pair_taken;
    logic  single_taken;
  } result_t;

  typedef struct packed {
    logic advance;
  } pipe_ctrl_t;

endpackage

>>> design/bwm_in_reg.sv
// Input register: captures one offered item per transfer.
// Depends on bwm_pkg.
module bwm_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bwm_pkg::item_t in_item,
  input  logic          advance,
  output logic          hold_valid,
  output bwm_pkg::item_t hold_item
);
  import bwm_pkg::*;

  // Free when empty or when the held item moves on this cycle
  assign in_ready = !hold_valid || advance;

  // Hold control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule

>>> design/bwm_step.sv
// Merger state and the per-item step: slot loading, burst lock and beat emission.
// Depends on bwm_pkg.
module bwm_step (
  input  logic              clk,
  input  logic              rst,
  input  bwm_pkg::pipe_ctrl_t ctrl,
  input  bwm_pkg::item_t    item,
  output bwm_pkg::result_t  result
);
  import bwm_pkg::*;

  logic              pair_held, pair_held_next;
  logic              pair_first_pending, pair_first_pending_next;
  logic              pair_slot_has_second;
  part_t             pair_slot_first, pair_slot_second;
  logic              single_held, single_held_next;
  part_t             single_slot;
  logic [SIZE_W-1:0] bytes_left, bytes_left_next;
  logic              locked_source, locked_source_next;

  logic              load_pair, load_single;
  logic              ph, pfp, phs, sh;
  part_t             pfirst, psecond, sgl;
  logic [SIZE_W-1:0] bl;
  logic              ls;
  logic              emit;
  part_t             sent;

  // Slot contents as seen after this item's loads
  always_comb begin
    load_pair   = !pair_held && item.pair_offer;
    load_single = !single_held && item.single_offer;
    ph      = pair_held || load_pair;
    pfp     = load_pair ? 1'b1 : pair_first_pending;
    phs     = load_pair ? item.pair_has_second : pair_slot_has_second;
    pfirst  = load_pair ? item.pair_first : pair_slot_first;
    psecond = load_pair ? item.pair_second : pair_slot_second;
    sh      = single_held || load_single;
    sgl     = load_single ? item.single : single_slot;
  end

  // Open a burst when none is running, pair source first
  always_comb begin
    bl = bytes_left;
    ls = locked_source;
    if (bytes_left == '0) begin
      if (ph) begin
        bl = pfirst.size;
        ls = SRC_PAIR;
      end else if (sh) begin
        bl = sgl.size;
        ls = SRC_SINGLE;
      end
    end
  end

  // Emit one part from the locked source, or stall if it holds nothing
  always_comb begin
    emit = (bl != '0) && ((ls == SRC_PAIR) ? ph : sh);
    if (ls == SRC_SINGLE) begin
      sent = sgl;
    end else if (pfp) begin
      sent = pfirst;
    end else begin
      sent = psecond;
    end

    pair_held_next          = ph && !(emit && ls == SRC_PAIR && (!pfp || !phs));
    pair_first_pending_next = (emit && ls == SRC_PAIR) ? 1'b0 : pfp;
    single_held_next        = sh && !(emit && ls == SRC_SINGLE);
    locked_source_next      = ls;
    if (!emit) begin
      bytes_left_next = bl;
    end else if (bl > BEAT_SIZE) begin
      bytes_left_next = bl - BEAT_SIZE;
    end else begin
      bytes_left_next = '0;
    end

    result.out_valid       = emit;
    result.sent.size       = emit ? sent.size : '0;
    result.sent.payload    = emit ? (sent.payload & PAYLOAD_MASK) : '0;
    result.out_source      = emit ? ls : 1'b0;
    result.pair_taken      = load_pair;
    result.single_taken    = load_single;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_held          <= 1'b0;
      pair_first_pending <= 1'b1;
      single_held        <= 1'b0;
      bytes_left         <= '0;
      locked_source      <= SRC_PAIR;
    end else if (ctrl.advance) begin
      pair_held          <= pair_held_next;
      pair_first_pending <= pair_first_pending_next;
      single_held        <= single_held_next;
      bytes_left         <= bytes_left_next;
      locked_source      <= locked_source_next;
    end
  end

  // Slot payloads, written on load only
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_slot_has_second <= 1'b0;
    end else if (ctrl.advance && load_pair) begin
      pair_slot_has_second <= item.pair_has_second;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance && load_pair) begin
      pair_slot_first  <= item.pair_first;
      pair_slot_second <= item.pair_second;
    end
    if (ctrl.advance && load_single) begin
      single_slot <= item.single;
    end
  end

endmodule

>>> design/bwm_out_reg.sv
// Result register: holds one result until its transfer completes.
// Depends on bwm_pkg.
module bwm_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  bwm_pkg::result_t result_in,
  output logic             res_valid,
  input  logic             res_ready,
  output bwm_pkg::result_t result_q
);
  import bwm_pkg::*;

  // Valid control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Load a new result
  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result_in;
    end
  end

endmodule

>>> design/burst_locked_write_request_merger_core.sv
// Channel   | Handshake            | Carries
// input     | in_valid / in_ready  | pair and single offers with sizes and payloads
// result    | res_valid / res_ready| emitted part, source, taken flags
//
// From input transfer to result, each item passes the input register, then
// the step logic into the result register. One item per cycle is sustained
// while the result channel is not stalled; the step logic and merger state update once per item.
// A stalled result register holds the input register, which then backs up
// the input channel. Reset is synchronous; holding slots come out empty.
// Depends on bwm_pkg, bwm_in_reg, bwm_step, bwm_out_reg and the macros header.
module burst_locked_write_request_merger_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           pair_offer,
  input  logic [bwm_pkg::SIZE_W-1:0]     pair_first_size,
  input  logic [bwm_pkg::PAYLOAD_W-1:0]  pair_first_payload,
  input  logic [bwm_pkg::SIZE_W-1:0]     pair_second_size,
  input  logic [bwm_pkg::PAYLOAD_W-1:0]  pair_second_payload,
  input  logic                           pair_has_second,
  input  logic                           single_offer,
  input  logic [bwm_pkg::SIZE_W-1:0]     single_size,
  input  logic [bwm_pkg::PAYLOAD_W-1:0]  single_payload,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic                           out_valid,
  output logic [bwm_pkg::SIZE_W-1:0]     out_size,
  output logic [bwm_pkg::PAYLOAD_W-1:0]  out_payload,
  output logic                           out_source,
  output logic                           pair_taken,
  output logic                           single_taken
);
  import bwm_pkg::*;

`include "burst_locked_write_request_merger_core_macros.svh"

  item_t      in_item, hold_item;
  logic       hold_valid;
  pipe_ctrl_t ctrl;
  result_t    step_result, result_q;
  logic       idle_clear;

  // Pack input fields
  always_comb begin
    in_item.pair_offer          = pair_offer;
    in_item.pair_first.size     = pair_first_size;
    in_item.pair_first.payload  = pair_first_payload;
    in_item.pair_second.size    = pair_second_size;
    in_item.pair_second.payload = pair_second_payload;
    in_item.pair_has_second     = pair_has_second;
    in_item.single_offer        = single_offer;
    in_item.single.size         = single_size;
    in_item.single.payload      = single_payload;
  end

  // Advance the held item when the result register can take it
  always_comb begin
    ctrl.advance = hold_valid && (!res_valid || res_ready);
  end

  bwm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (ctrl.advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  bwm_step u_step (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .item   (hold_item),
    .result (step_result)
  );

  bwm_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (ctrl.advance),
    .result_in (step_result),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result_q  (result_q)
  );

  // Unpack result fields
  assign out_valid    = result_q.out_valid;
  assign out_size     = result_q.sent.size;
  assign out_payload  = result_q.sent.payload;
  assign out_source   = result_q.out_source;
  assign pair_taken   = result_q.pair_taken;
  assign single_taken = result_q.single_taken;

  // Idle result carries all-zero part fields
  assign idle_clear = (out_size == '0) && (out_payload == '0) && (out_source == 1'b0);

  // Checks
  `BWM_ASSERT_NOW(a_idle_fields_zero, res_valid && !out_valid, idle_clear, "idle result not cleared")
  `BWM_ASSERT_NOW(a_ready_when_empty, !res_valid, in_ready, "input stalled with empty result")
  `BWM_ASSERT_NOW(a_clean_after_reset, $past(rst), !res_valid, "result valid after reset")
  `BWM_ASSERT_NEXT(a_result_follows, ctrl.advance, res_valid, "advanced item lost")

endmodule
